@@ rtl/core/bitmask_overlap_collision_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bitmask overlap collision block
// Same-cycle and next-cycle implications, clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef BITMASK_OVERLAP_COLLISION_TOP_ASSERT_SVH
`define BITMASK_OVERLAP_COLLISION_TOP_ASSERT_SVH

// cons holds in the same cycle as ante
`define BOCOL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bocol assertion failed");

// cons holds in the cycle after ante
`define BOCOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bocol assertion failed");

`endif

@@ rtl/core/bocol_pkg.sv @@
// ----------------------------------------------------------------------------
// bocol_pkg
// Types, constants and codes shared by the bitmask overlap collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package bocol_pkg;

  localparam int MAX_DIM   = 32;
  localparam int ADDR_W    = $clog2(MAX_DIM);
  localparam int ROW_W     = 32;
  localparam int DIM_W     = 6;
  localparam int LEN_W     = $clog2(MAX_DIM) + 1;
  localparam int OFF_W     = 8;
  localparam int KIND_W    = 2;
  localparam int ROWIDX_W  = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_A_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_HEIGHT = 3'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

  typedef struct packed {
    logic [DIM_W-1:0] a_width;
    logic [DIM_W-1:0] a_height;
    logic [DIM_W-1:0] b_width;
    logic [DIM_W-1:0] b_height;
  } dims_t;

  typedef struct packed {
    logic                    start;
    logic signed [OFF_W-1:0] x_offset;
    logic signed [OFF_W-1:0] y_offset;
  } qry_req_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic overlap;
  } qry_res_t;

  typedef struct packed {
    logic              en_a;
    logic              en_b;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } mem_rd_t;

endpackage

`default_nettype wire

@@ rtl/core/bocol_mask_mem.sv @@
// ----------------------------------------------------------------------------
// bocol_mask_mem
// Row stores for masks A and B: one write port, one registered read per mask.
// ----------------------------------------------------------------------------
`default_nettype none

module bocol_mask_mem (
  input  logic                                      clk,
  input  logic                                      rst,
  input  bocol_pkg::mem_wr_t                        wr,
  input  bocol_pkg::mem_rd_t                        rd,
  output logic [bocol_pkg::ROW_W-1:0]               rd_data_a,
  output logic [bocol_pkg::ROW_W-1:0]               rd_data_b
);

  logic [bocol_pkg::ROW_W-1:0]   mem_a [bocol_pkg::MAX_DIM];
  logic [bocol_pkg::ROW_W-1:0]   mem_b [bocol_pkg::MAX_DIM];
  logic [bocol_pkg::MAX_DIM-1:0] vld_a;
  logic [bocol_pkg::MAX_DIM-1:0] vld_b;
  logic [bocol_pkg::ROW_W-1:0]   data_a_q;
  logic [bocol_pkg::ROW_W-1:0]   data_b_q;
  logic                          vld_a_q;
  logic                          vld_b_q;

  always_ff @(posedge clk) begin
    if (wr.en_a) begin
      mem_a[wr.addr] <= wr.data;
    end
    if (wr.en_b) begin
      mem_b[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= '0;
      vld_b <= '0;
    end else begin
      if (wr.en_a) begin
        vld_a[wr.addr] <= 1'b1;
      end
      if (wr.en_b) begin
        vld_b[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      data_a_q <= mem_a[rd.addr_a];
      data_b_q <= mem_b[rd.addr_b];
      vld_a_q  <= vld_a[rd.addr_a];
      vld_b_q  <= vld_b[rd.addr_b];
    end
  end

  // rows never written read as zero
  assign rd_data_a = vld_a_q ? data_a_q : '0;
  assign rd_data_b = vld_b_q ? data_b_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/bocol_query.sv @@
// ----------------------------------------------------------------------------
// bocol_query
// Query sequencer: overlap extent, corners, then one row pair read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bocol_query (
  input  logic                              clk,
  input  logic                              rst,
  input  bocol_pkg::qry_req_t               req,
  input  bocol_pkg::dims_t                  dims,
  input  logic                              ack,
  output bocol_pkg::qry_res_t               res,
  output logic                              idle,
  output bocol_pkg::mem_rd_t                rd,
  input  logic [bocol_pkg::ROW_W-1:0]       rd_data_a,
  input  logic [bocol_pkg::ROW_W-1:0]       rd_data_b
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CALC   = 6'b000010,
    S_CORNER = 6'b000100,
    S_SCAN   = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic signed [bocol_pkg::OFF_W-1:0] xo;
  logic signed [bocol_pkg::OFF_W-1:0] yo;
  logic [bocol_pkg::LEN_W-1:0]        xov;
  logic [bocol_pkg::LEN_W-1:0]        yov;
  logic                               ovl;
  logic [bocol_pkg::ADDR_W-1:0]       x1;
  logic [bocol_pkg::ADDR_W-1:0]       x2;
  logic [bocol_pkg::ADDR_W-1:0]       y1;
  logic [bocol_pkg::ADDR_W-1:0]       y2;
  logic [bocol_pkg::ROW_W-1:0]        colmask;
  logic [bocol_pkg::ADDR_W-1:0]       j;
  logic                               rd_pend;
  logic                               hit_acc;

  logic [bocol_pkg::LEN_W-1:0] aw, ah, bw, bh;
  logic signed [9:0]           xlen, ylen;
  logic                        last_row;

  function automatic logic [bocol_pkg::LEN_W-1:0] clamp_dim(
    input logic [bocol_pkg::DIM_W-1:0] d
  );
    return (d > bocol_pkg::DIM_W'(bocol_pkg::MAX_DIM)) ?
           bocol_pkg::LEN_W'(bocol_pkg::MAX_DIM) : bocol_pkg::LEN_W'(d);
  endfunction

  function automatic logic signed [9:0] overlap_len(
    input logic [bocol_pkg::LEN_W-1:0]        da,
    input logic [bocol_pkg::LEN_W-1:0]        db,
    input logic signed [bocol_pkg::OFF_W-1:0] off
  );
    logic [bocol_pkg::LEN_W:0]   sum;
    logic [bocol_pkg::OFF_W-1:0] mag;
    logic signed [9:0]           o;
    logic signed [9:0]           lim;
    sum = {1'b0, da} + {1'b0, db};
    mag = off[bocol_pkg::OFF_W-1] ? bocol_pkg::OFF_W'(-off) : bocol_pkg::OFF_W'(off);
    o   = $signed(10'(sum >> 1)) - $signed(10'(mag));
    lim = $signed(10'((da < db) ? da : db));
    return (o > lim) ? lim : o;
  endfunction

  assign aw = clamp_dim(dims.a_width);
  assign ah = clamp_dim(dims.a_height);
  assign bw = clamp_dim(dims.b_width);
  assign bh = clamp_dim(dims.b_height);

  assign xlen = overlap_len(aw, bw, xo);
  assign ylen = overlap_len(ah, bh, yo);

  assign last_row = (bocol_pkg::LEN_W'(j) + bocol_pkg::LEN_W'(1)) == yov;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          state_next = S_CALC;
        end
      end
      S_CALC:   state_next = S_CORNER;
      S_CORNER: state_next = ovl ? S_SCAN : S_DONE;
      S_SCAN: begin
        if (last_row) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_DONE;
      S_DONE: begin
        if (ack) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd.en;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.start) begin
          xo <= req.x_offset;
          yo <= req.y_offset;
        end
      end
      S_CALC: begin
        ovl <= (xlen > 10'sd0) && (ylen > 10'sd0);
        xov <= bocol_pkg::LEN_W'(xlen);
        yov <= bocol_pkg::LEN_W'(ylen);
      end
      S_CORNER: begin
        x1      <= xo[bocol_pkg::OFF_W-1] ? bocol_pkg::ADDR_W'(aw - xov) : '0;
        x2      <= xo[bocol_pkg::OFF_W-1] ? '0 : bocol_pkg::ADDR_W'(bw - xov);
        y1      <= yo[bocol_pkg::OFF_W-1] ? bocol_pkg::ADDR_W'(ah - yov) : '0;
        y2      <= yo[bocol_pkg::OFF_W-1] ? '0 : bocol_pkg::ADDR_W'(bh - yov);
        colmask <= bocol_pkg::ROW_W'(((bocol_pkg::ROW_W + 1)'(1) << xov)
                   - (bocol_pkg::ROW_W + 1)'(1));
        j       <= '0;
        hit_acc <= 1'b0;
      end
      S_SCAN: begin
        j <= j + bocol_pkg::ADDR_W'(1);
      end
      default: begin
      end
    endcase
    if (rd_pend) begin
      hit_acc <= hit_acc | (|((rd_data_a >> x1) & (rd_data_b >> x2) & colmask));
    end
  end

  always_comb begin
    rd.en     = (state == S_SCAN);
    rd.addr_a = y1 + j;
    rd.addr_b = y2 + j;
  end

  assign res.done    = (state == S_DONE);
  assign res.hit     = hit_acc;
  assign res.overlap = ovl;
  assign idle        = (state == S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/bitmask_overlap_collision_top.sv @@
// ----------------------------------------------------------------------------
// bitmask_overlap_collision_top
// Pixel-exact collision test between two sprite bit masks of up to 32x32.
//
// Input channel (in_valid / in_stall): kind 0 and 1 load one 32-bit row of
// mask A or B at row_index; kind 2 is a query with centre offsets x_offset,
// y_offset; kind 3 is taken and dropped. Loads give no result. A query
// gives one result (hit, boxes_overlap) on the output channel (out_valid /
// out_stall). The row scan reads one row pair per cycle from the mask
// memories; in_stall stays high from a query transfer until its result
// moves into the output register, so the next item can transfer only
// after that. A stalled result holds in the output register while the
// next item is taken; a second query then waits finished inside the block.
// The user must write registers on the cfg port only while the block is
// idle; the block itself does not enforce this.
// Reset clears both masks to zero and sets all four dimensions to 32.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmask_overlap_collision_top_assert.svh"

module bitmask_overlap_collision_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [bocol_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bocol_pkg::DIM_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [bocol_pkg::KIND_W-1:0]           kind,
  input  logic [bocol_pkg::ROWIDX_W-1:0]         row_index,
  input  logic [bocol_pkg::ROW_W-1:0]            row_bits,
  input  logic signed [bocol_pkg::OFF_W-1:0]     x_offset,
  input  logic signed [bocol_pkg::OFF_W-1:0]     y_offset,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   hit,
  output logic                                   boxes_overlap
);

  bocol_pkg::dims_t     dims;
  bocol_pkg::qry_req_t  req;
  bocol_pkg::qry_res_t  res;
  bocol_pkg::mem_wr_t   wr;
  bocol_pkg::mem_rd_t   rd;
  logic                 eng_idle;
  logic                 in_xfer;
  logic                 row_ok;
  logic                 ack;
  logic [bocol_pkg::ROW_W-1:0] rd_data_a;
  logic [bocol_pkg::ROW_W-1:0] rd_data_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.a_width  <= bocol_pkg::DIM_RESET;
      dims.a_height <= bocol_pkg::DIM_RESET;
      dims.b_width  <= bocol_pkg::DIM_RESET;
      dims.b_height <= bocol_pkg::DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bocol_pkg::REG_A_WIDTH:  dims.a_width  <= cfg_data;
        bocol_pkg::REG_A_HEIGHT: dims.a_height <= cfg_data;
        bocol_pkg::REG_B_WIDTH:  dims.b_width  <= cfg_data;
        bocol_pkg::REG_B_HEIGHT: dims.b_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !eng_idle;
  assign in_xfer  = in_valid && !in_stall;
  assign row_ok   = 32'(row_index) < bocol_pkg::MAX_DIM;

  always_comb begin
    wr.en_a = in_xfer && row_ok && (kind == bocol_pkg::KIND_LOAD_A);
    wr.en_b = in_xfer && row_ok && (kind == bocol_pkg::KIND_LOAD_B);
    wr.addr = bocol_pkg::ADDR_W'(row_index);
    wr.data = row_bits;
  end

  always_comb begin
    req.start    = in_xfer && (kind == bocol_pkg::KIND_QUERY);
    req.x_offset = x_offset;
    req.y_offset = y_offset;
  end

  bocol_mask_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd        (rd),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  bocol_query u_query (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .dims      (dims),
    .ack       (ack),
    .res       (res),
    .idle      (eng_idle),
    .rd        (rd),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign ack = res.done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      hit           <= res.hit;
      boxes_overlap <= res.overlap;
    end
  end

  `BOCOL_ASSERT_NEXT(a_query_blocks_input, req.start, in_stall)
  `BOCOL_ASSERT_SAME(a_hit_needs_overlap, out_valid && hit, boxes_overlap)
  `BOCOL_ASSERT_NEXT(a_result_waits, res.done && out_valid && out_stall, res.done)

endmodule

`default_nettype wire

@@ verif/tb_bitmask_overlap_collision_top.sv @@
// ----------------------------------------------------------------------------
// tb_bitmask_overlap_collision_top
// Loads rows of the two sprite masks and fires collision queries through the
// valid/stall input, then checks each hit / boxes_overlap transfer in order
// against an in-bench model of both masks and the four dimension registers.
// Runs a directed corner set, then random phases under varied dimensions and
// sender/receiver idling, with a full drain between phases.
// ----------------------------------------------------------------------------
module tb_bitmask_overlap_collision_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bocol_pkg::KIND_W-1:0]    KIND_UNUSED     = 2'd3;
  localparam logic [bocol_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO   = 3'd4;
  localparam logic [bocol_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI   = 3'd7;
  localparam int                              NUM_PHASES      = 8;
  localparam int                              OPS_PER_PHASE   = 60;
  localparam int                              SETTLE_CYCLES   = 40;
  localparam int                              STUCK_LIMIT     = 2000;
  localparam int                              MAX_REPORTS     = 10;

  typedef struct {
    logic [bocol_pkg::KIND_W-1:0]          kind;
    logic [bocol_pkg::ROWIDX_W-1:0]        row;
    logic [bocol_pkg::ROW_W-1:0]           bits;
    logic signed [bocol_pkg::OFF_W-1:0]    xo;
    logic signed [bocol_pkg::OFF_W-1:0]    yo;
  } sprite_op_t;

  typedef struct packed {
    logic hit;
    logic boxes_overlap;
  } collision_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  cfg_wr_en = 1'b0;
  logic [bocol_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [bocol_pkg::DIM_W-1:0]           cfg_data = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic [bocol_pkg::KIND_W-1:0]          kind = '0;
  logic [bocol_pkg::ROWIDX_W-1:0]        row_index = '0;
  logic [bocol_pkg::ROW_W-1:0]           row_bits = '0;
  logic signed [bocol_pkg::OFF_W-1:0]    x_offset = '0;
  logic signed [bocol_pkg::OFF_W-1:0]    y_offset = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic                                  hit;
  logic                                  boxes_overlap;

  sprite_op_t                  pending_sprite_ops[$];
  collision_t                  expected_collisions[$];
  logic [bocol_pkg::ROW_W-1:0] sprite_a_rows [bocol_pkg::MAX_DIM];
  logic [bocol_pkg::ROW_W-1:0] sprite_b_rows [bocol_pkg::MAX_DIM];
  bocol_pkg::dims_t            sprite_dims;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int ops_taken = 0;
  int queries_taken = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int disjoint_seen = 0;
  int reg_writes = 0;
  int error_count = 0;
  int stuck_cycles = 0;

  bitmask_overlap_collision_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .row_index     (row_index),
    .row_bits      (row_bits),
    .x_offset      (x_offset),
    .y_offset      (y_offset),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .boxes_overlap (boxes_overlap)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clip_dim(logic [bocol_pkg::DIM_W-1:0] d);
    return (d > bocol_pkg::MAX_DIM) ? bocol_pkg::MAX_DIM : int'(d);
  endfunction

  function automatic int overlap_span(int da, int db, int off);
    int mag;
    int len;
    int lim;
    mag = (off < 0) ? -off : off;
    len = (da + db) / 2 - mag;
    lim = (da < db) ? da : db;
    return (len > lim) ? lim : len;
  endfunction

  function automatic collision_t predict_collision(
    logic signed [bocol_pkg::OFF_W-1:0] xo,
    logic signed [bocol_pkg::OFF_W-1:0] yo
  );
    collision_t res;
    int aw, ah, bw, bh, xov, yov, xa, xb, ya, yb, j;
    logic [63:0] ra, rb, cols;
    res = '0;
    aw = clip_dim(sprite_dims.a_width);
    ah = clip_dim(sprite_dims.a_height);
    bw = clip_dim(sprite_dims.b_width);
    bh = clip_dim(sprite_dims.b_height);
    xov = overlap_span(aw, bw, int'(xo));
    yov = overlap_span(ah, bh, int'(yo));
    if (xov > 0 && yov > 0) begin
      res.boxes_overlap = 1'b1;
      xa = (xo < 0) ? aw - xov : 0;
      xb = (xo < 0) ? 0 : bw - xov;
      ya = (yo < 0) ? ah - yov : 0;
      yb = (yo < 0) ? 0 : bh - yov;
      cols = (64'd1 << xov) - 64'd1;
      for (j = 0; j < yov; j++) begin
        ra = {32'd0, sprite_a_rows[ya + j]} >> xa;
        rb = {32'd0, sprite_b_rows[yb + j]} >> xb;
        if ((ra & rb & cols) != 64'd0) res.hit = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [bocol_pkg::ROW_W-1:0] pick_row_bits();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3, 4: return 32'd1 << $urandom_range(31);
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  function automatic logic signed [bocol_pkg::OFF_W-1:0] pick_offset();
    int v;
    if ($urandom_range(9) == 0) v = $urandom_range(255);
    else v = int'($urandom_range(80)) - 40;
    return v[bocol_pkg::OFF_W-1:0];
  endfunction

  task automatic push_op(logic [bocol_pkg::KIND_W-1:0] k,
                         logic [bocol_pkg::ROWIDX_W-1:0] r,
                         logic [bocol_pkg::ROW_W-1:0] b, int xo, int yo);
    sprite_op_t op;
    op.kind = k;
    op.row  = r;
    op.bits = b;
    op.xo   = xo[bocol_pkg::OFF_W-1:0];
    op.yo   = yo[bocol_pkg::OFF_W-1:0];
    pending_sprite_ops.push_back(op);
  endtask

  task automatic push_random_op();
    sprite_op_t op;
    int r;
    r = $urandom_range(99);
    if (r < 35) op.kind = bocol_pkg::KIND_LOAD_A;
    else if (r < 70) op.kind = bocol_pkg::KIND_LOAD_B;
    else if (r < 97) op.kind = bocol_pkg::KIND_QUERY;
    else op.kind = KIND_UNUSED;
    op.row  = bocol_pkg::ROWIDX_W'($urandom_range(bocol_pkg::MAX_DIM - 1));
    op.bits = pick_row_bits();
    op.xo   = pick_offset();
    op.yo   = pick_offset();
    pending_sprite_ops.push_back(op);
  endtask

  task automatic write_reg(logic [bocol_pkg::CFG_IDX_W-1:0] idx,
                           logic [bocol_pkg::DIM_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
    case (idx)
      bocol_pkg::REG_A_WIDTH:  sprite_dims.a_width  = val;
      bocol_pkg::REG_A_HEIGHT: sprite_dims.a_height = val;
      bocol_pkg::REG_B_WIDTH:  sprite_dims.b_width  = val;
      bocol_pkg::REG_B_HEIGHT: sprite_dims.b_height = val;
      default: ;
    endcase
  endtask

  task automatic set_dims(int aw, int ah, int bw, int bh);
    write_reg(bocol_pkg::REG_A_WIDTH,  aw[bocol_pkg::DIM_W-1:0]);
    write_reg(bocol_pkg::REG_A_HEIGHT, ah[bocol_pkg::DIM_W-1:0]);
    write_reg(bocol_pkg::REG_B_WIDTH,  bw[bocol_pkg::DIM_W-1:0]);
    write_reg(bocol_pkg::REG_B_HEIGHT, bh[bocol_pkg::DIM_W-1:0]);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_sprite_ops.size() != 0 || in_valid || expected_collisions.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver: hold a stalled transfer, otherwise present the next op or idle
  always @(posedge clk) begin
    sprite_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ops_taken++;
        case (kind)
          bocol_pkg::KIND_LOAD_A: sprite_a_rows[row_index] = row_bits;
          bocol_pkg::KIND_LOAD_B: sprite_b_rows[row_index] = row_bits;
          bocol_pkg::KIND_QUERY: begin
            queries_taken++;
            expected_collisions.push_back(predict_collision(x_offset, y_offset));
          end
          default: ;
        endcase
      end
      if (!in_valid || !in_stall) begin
        if (pending_sprite_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = pending_sprite_ops.pop_front();
          in_valid  <= 1'b1;
          kind      <= op.kind;
          row_index <= op.row;
          row_bits  <= op.bits;
          x_offset  <= op.xo;
          y_offset  <= op.yo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    collision_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (hit) hits_seen++;
        if (!boxes_overlap) disjoint_seen++;
        if (expected_collisions.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result with nothing pending: hit=%0b boxes_overlap=%0b",
                     $realtime, hit, boxes_overlap);
        end else begin
          want = expected_collisions.pop_front();
          if (hit !== want.hit || boxes_overlap !== want.boxes_overlap) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: mismatch: expected hit=%0b boxes_overlap=%0b, got %0b %0b",
                       $realtime, want.hit, want.boxes_overlap, hit, boxes_overlap);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no transfer in %0d cycles", $realtime, STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int ph, i;
    for (i = 0; i < bocol_pkg::MAX_DIM; i++) begin
      sprite_a_rows[i] = '0;
      sprite_b_rows[i] = '0;
    end
    sprite_dims = '{bocol_pkg::DIM_RESET, bocol_pkg::DIM_RESET,
                    bocol_pkg::DIM_RESET, bocol_pkg::DIM_RESET};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed corners under reset dimensions
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, 0, 0);
    push_op(bocol_pkg::KIND_QUERY,  5'd31, 32'h0, 127, -128);
    push_op(KIND_UNUSED,            5'd31, 32'hFFFF_FFFF, -1, -1);
    push_op(bocol_pkg::KIND_LOAD_A, 5'd0,  32'hFFFF_FFFF, 0, 0);
    push_op(bocol_pkg::KIND_LOAD_A, 5'd31, 32'hFFFF_FFFF, 0, 0);
    push_op(bocol_pkg::KIND_LOAD_B, 5'd0,  32'h8000_0001, 0, 0);
    push_op(bocol_pkg::KIND_LOAD_B, 5'd31, 32'h8000_0000, 0, 0);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, 0, 0);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, 31, 31);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, -31, -31);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, 31, -31);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, -31, 31);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, 32, 0);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, -32, 5);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, 64, -64);
    push_op(bocol_pkg::KIND_LOAD_A, 5'd0,  32'h0, 0, 0);
    push_op(bocol_pkg::KIND_LOAD_A, 5'd21, 32'h5555_5555, 0, 0);
    push_op(bocol_pkg::KIND_LOAD_B, 5'd10, 32'hAAAA_AAAA, 0, 0);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, 0, 11);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, 1, 11);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, -1, -11);
    push_op(bocol_pkg::KIND_QUERY,  5'd0,  32'h0, 1, -1);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_UNUSED_LO, 6'h3F);
          write_reg(REG_UNUSED_HI, 6'h00);
          set_dims(32, 32, 32, 32);
        end
        1: set_dims(1, 1, 1, 1);
        2: set_dims(63, 0, 17, 63);
        3: set_dims(5, 32, 32, 3);
        7: set_dims($urandom_range(63), $urandom_range(63),
                    $urandom_range(63), $urandom_range(63));
        default: set_dims($urandom_range(1, 32), $urandom_range(1, 32),
                          $urandom_range(1, 32), $urandom_range(1, 32));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      repeat (OPS_PER_PHASE) push_random_op();
      drain();
    end

    $display("Ran %0d transfers (%0d queries) over %0d register writes in %0d phases",
             ops_taken, queries_taken, reg_writes, NUM_PHASES + 1);
    $display("Results: %0d checked, %0d hits, %0d with disjoint boxes, %0d errors",
             results_seen, hits_seen, disjoint_seen, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bocol_pkg.sv
rtl/core/bocol_mask_mem.sv
rtl/core/bocol_query.sv
rtl/core/bitmask_overlap_collision_top.sv
verif/tb_bitmask_overlap_collision_top.sv
